// ===== rtl/zsub_pkg.sv =====
// Types, codes and CRC helpers shared by the ZMODEM data subpacket receiver.
package zsub_pkg;

	localparam int COUNT_LIMIT = 1024;
	localparam int CNT_W = 11;

	// symbol kinds
	localparam logic [2:0] KIND_DATA      = 3'd0;
	localparam logic [2:0] KIND_FRAME_END = 3'd1;
	localparam logic [2:0] KIND_CANCEL    = 3'd2;
	localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
	localparam logic [2:0] KIND_BAD_ESC   = 3'd4;

	// result kinds
	localparam logic RES_DATA = 1'b0;
	localparam logic RES_END  = 1'b1;

	// end status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_CRC   = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_TIMEOUT   = 3'd3;
	localparam logic [2:0] ST_BAD_SUB   = 3'd4;
	localparam logic [2:0] ST_TOO_LONG  = 3'd5;

	// configuration register indexes
	localparam logic CFG_CRC32_MODE = 1'b0;
	localparam logic CFG_MAX_LENGTH = 1'b1;

	localparam logic [31:0] CRC32_INIT    = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC32_RESIDUE = 32'hDEBB_20E3;
	localparam logic [31:0] CRC32_POLY    = 32'hEDB8_8320;
	localparam logic [15:0] CRC16_POLY    = 16'h1021;

	typedef struct packed {
		logic [2:0] symbol_kind;
		logic [7:0] symbol_value;
	} sym_t;

	typedef struct packed {
		logic             result_kind;
		logic [7:0]       data_byte;
		logic [2:0]       status;
		logic [CNT_W-1:0] byte_count;
		logic             last;
	} res_t;

	function automatic logic [15:0] fold16(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC16_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [31:0] fold32(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = {1'b0, c[31:1]} ^ CRC32_POLY;
			else
				c = {1'b0, c[31:1]};
		end
		return c;
	endfunction

endpackage

// ===== rtl/zmodem_data_subpacket_receiver_unit.sv =====
// ZMODEM data subpacket receiver: byte pass-through, counting and CRC-16/CRC-32 check.
//
// Input channel sym (sym_valid/sym_stall) carries decoded symbols: data bytes,
// frame end with its end character, cancel, timeout, bad escape.
// Output channel res (res_valid/res_stall) carries one data request per data
// byte collected within the length limit and one end request with status that closes a subpacket.
// Frame-end and CRC tail symbols produce no request until the last tail byte.
// Config port: cfg_we writes cfg_data into register cfg_index (0 crc32_mode,
// 1 max_length); it is to be written only while idle, which the block does not
// enforce. A mode write drops the subpacket. A symbol's request passes
// through the input register, then the result register. Throughput: one
// symbol per cycle while res_stall is low; the byte-wide CRC update is combinational.
// When res_stall holds against a pending request, the result register and input
// register both hold and sym_stall rises once both are full.
// Reset clears both pipeline stages, selects CRC-16, max_length 1024,
// and starts collecting a fresh subpacket.
module zmodem_data_subpacket_receiver_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sym_valid,
	output logic                       sym_stall,
	input  zsub_pkg::sym_t             sym,
	output logic                       res_valid,
	input  logic                       res_stall,
	output zsub_pkg::res_t             res,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [zsub_pkg::CNT_W-1:0] cfg_data
);

	localparam logic PH_COLLECT = 1'b0;
	localparam logic PH_TAIL    = 1'b1;

	logic                       crc32_mode_q;
	logic [zsub_pkg::CNT_W-1:0] max_length_q;
	logic                       phase_q;
	logic [31:0]                crc_q;
	logic [zsub_pkg::CNT_W-1:0] count_q;
	logic [2:0]                 tail_q;
	logic [7:0]                 end_char_q;

	logic           valid_s1;
	zsub_pkg::sym_t sym_s1;
	logic           res_valid_q;
	zsub_pkg::res_t res_q;

	logic adv;
	assign adv       = !res_valid_q || !res_stall;
	assign sym_stall = valid_s1 && !adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// next-state / result logic for the symbol in s1
	logic [31:0]                crc_fold;
	logic [zsub_pkg::CNT_W-1:0] limit;
	logic [2:0]                 tail_dec;
	logic                       crc_good;
	logic                       emit;
	logic                       finish;
	zsub_pkg::res_t             res_d;
	logic                       phase_d;
	logic [31:0]                crc_d;
	logic [zsub_pkg::CNT_W-1:0] count_d;
	logic [2:0]                 tail_d;
	logic [7:0]                 end_char_d;

	always_comb begin
		if (crc32_mode_q)
			crc_fold = zsub_pkg::fold32(crc_q, sym_s1.symbol_value);
		else
			crc_fold = {16'h0, zsub_pkg::fold16(crc_q[15:0], sym_s1.symbol_value)};
	end

	always_comb begin
		if (max_length_q > zsub_pkg::CNT_W'(zsub_pkg::COUNT_LIMIT))
			limit = zsub_pkg::CNT_W'(zsub_pkg::COUNT_LIMIT);
		else
			limit = max_length_q;
	end

	assign tail_dec = (tail_q != 3'd0) ? tail_q - 3'd1 : 3'd0;
	assign crc_good = crc32_mode_q ? (crc_fold == zsub_pkg::CRC32_RESIDUE)
	                               : (crc_fold[15:0] == 16'h0);

	always_comb begin
		emit             = 1'b0;
		finish           = 1'b0;
		res_d.result_kind = zsub_pkg::RES_END;
		res_d.data_byte  = 8'h00;
		res_d.status     = zsub_pkg::ST_OK;
		res_d.byte_count = count_q;
		res_d.last       = 1'b1;
		phase_d          = phase_q;
		crc_d            = crc_q;
		count_d          = count_q;
		tail_d           = tail_q;
		end_char_d       = end_char_q;
		case (sym_s1.symbol_kind)
			zsub_pkg::KIND_DATA: begin
				if (phase_q == PH_COLLECT) begin
					if (count_q >= limit) begin
						finish       = 1'b1;
						res_d.status = zsub_pkg::ST_TOO_LONG;
					end else begin
						emit              = 1'b1;
						crc_d             = crc_fold;
						count_d           = count_q + 1'b1;
						res_d.result_kind = zsub_pkg::RES_DATA;
						res_d.data_byte   = sym_s1.symbol_value;
						res_d.byte_count  = count_q + 1'b1;
						res_d.last        = 1'b0;
					end
				end else begin
					crc_d  = crc_fold;
					tail_d = tail_dec;
					if (tail_dec == 3'd0) begin
						finish = 1'b1;
						if (crc_good) begin
							res_d.status    = zsub_pkg::ST_OK;
							res_d.data_byte = end_char_q;
						end else begin
							res_d.status = zsub_pkg::ST_BAD_CRC;
						end
					end
				end
			end
			zsub_pkg::KIND_FRAME_END: begin
				crc_d      = crc_fold;
				end_char_d = sym_s1.symbol_value;
				phase_d    = PH_TAIL;
				tail_d     = crc32_mode_q ? 3'd4 : 3'd2;
			end
			zsub_pkg::KIND_CANCEL: begin
				finish       = 1'b1;
				res_d.status = zsub_pkg::ST_CANCELLED;
			end
			zsub_pkg::KIND_TIMEOUT: begin
				finish       = 1'b1;
				res_d.status = zsub_pkg::ST_TIMEOUT;
			end
			default: begin
				// bad escape and unused kinds
				finish       = 1'b1;
				res_d.status = zsub_pkg::ST_BAD_SUB;
			end
		endcase
		if (finish) begin
			emit       = 1'b1;
			phase_d    = PH_COLLECT;
			crc_d      = crc32_mode_q ? zsub_pkg::CRC32_INIT : 32'h0;
			count_d    = '0;
			tail_d     = 3'd0;
			end_char_d = 8'h00;
		end
	end

	// s1 fills whenever it is empty or drains into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!sym_stall)
				valid_s1 <= sym_valid;
			if (adv)
				res_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (!sym_stall)
			sym_s1 <= sym;
		if (adv)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc32_mode_q <= 1'b0;
			max_length_q <= zsub_pkg::CNT_W'(zsub_pkg::COUNT_LIMIT);
			phase_q      <= PH_COLLECT;
			crc_q        <= 32'h0;
			count_q      <= '0;
			tail_q       <= 3'd0;
			end_char_q   <= 8'h00;
		end else if (cfg_we) begin
			if (cfg_index == zsub_pkg::CFG_CRC32_MODE) begin
				crc32_mode_q <= cfg_data[0];
				phase_q      <= PH_COLLECT;
				crc_q        <= cfg_data[0] ? zsub_pkg::CRC32_INIT : 32'h0;
				count_q      <= '0;
				tail_q       <= 3'd0;
				end_char_q   <= 8'h00;
			end else begin
				max_length_q <= cfg_data;
			end
		end else if (valid_s1 && adv) begin
			phase_q    <= phase_d;
			crc_q      <= crc_d;
			count_q    <= count_d;
			tail_q     <= tail_d;
			end_char_q <= end_char_d;
		end
	end

`ifndef SYNTHESIS
	a_last_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.last == res_q.result_kind))
		else $error("last flag disagrees with result kind");

	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.result_kind == zsub_pkg::RES_DATA) |->
		(res_q.status == zsub_pkg::ST_OK))
		else $error("data request carries a nonzero status");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= zsub_pkg::CNT_W'(zsub_pkg::COUNT_LIMIT))
		else $error("byte count beyond limit");

	a_collect_no_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COLLECT) |-> (tail_q == 3'd0))
		else $error("tail count set while collecting");
`endif

endmodule
